// File: design/triangular_window_smoother_core_macros.svh
// assertion macros shared by the smoother rtl
`ifndef TRIANGULAR_WINDOW_SMOOTHER_CORE_MACROS_SVH
`define TRIANGULAR_WINDOW_SMOOTHER_CORE_MACROS_SVH

`ifndef SYNTH

`define TWS_ASSERT_SAME(lbl, ck, rs, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |-> (con)) \
    else $error("assertion failed: same-cycle implication");

`define TWS_ASSERT_NEXT(lbl, ck, rs, ant, con) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ant) |=> (con)) \
    else $error("assertion failed: next-cycle implication");

`else

`define TWS_ASSERT_SAME(lbl, ck, rs, ant, con)

`define TWS_ASSERT_NEXT(lbl, ck, rs, ant, con)

`endif

`endif

// File: design/tws_pkg.sv
// shared constants, types and weight functions for the smoother
package tws_pkg;

  localparam int MAX_WINDOW  = 15;
  localparam int SAMPLE_BITS = 16;
  localparam int WIN_W       = 4;
  localparam int WEIGHT_W    = 4;
  localparam int SUM_W       = 23;
  localparam int MAG_W       = 22;
  localparam int DIVISOR_W   = 7;
  localparam int CNT_W       = $clog2(MAX_WINDOW);
  localparam int STEP_W      = $clog2(MAG_W);
  localparam int ADDR_W      = 3;

  localparam logic WORD_WINDOW_SIZE = 1'b0;
  localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] psum_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_LOAD = 5'b00100,
    S_DIV  = 5'b01000,
    S_PEND = 5'b10000
  } state_t;

  function automatic logic [WIN_W-1:0] center_of(input logic [WIN_W-1:0] w);
    logic [WIN_W:0] wp;
    wp = {1'b0, w} + 1'b1;
    return wp[WIN_W:1];
  endfunction

  function automatic logic [WEIGHT_W-1:0] cell_weight(input logic [CNT_W-1:0] idx,
                                                      input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] c;
    logic [WEIGHT_W-1:0] wt;
    c = center_of(w);
    if (idx < c) begin
      wt = WEIGHT_W'(idx) + 1'b1;
    end else if (idx < w) begin
      wt = WEIGHT_W'(w - idx);
    end else begin
      wt = '0;
    end
    return wt;
  endfunction

  function automatic logic [DIVISOR_W-1:0] weight_total(input logic [WIN_W-1:0] w);
    logic [WIN_W-1:0] c;
    logic [2*WIN_W-1:0] sq;
    c = center_of(w);
    sq = c * c;
    return sq[DIVISOR_W-1:0];
  endfunction

  function automatic logic [WIN_W-1:0] fix_window(input logic [WIN_W-1:0] v);
    logic [WIN_W-1:0] r;
    if (v[0]) begin
      r = v;
    end else if (v == '0) begin
      r = WIN_W'(1);
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

endpackage

// File: design/tws_cell.sv
// one tap of the delay line with its weighted partial-sum stage
module tws_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  tws_pkg::sample_t              sample_in,
  input  logic [tws_pkg::WEIGHT_W-1:0]  weight,
  input  tws_pkg::psum_t                psum_in,
  output tws_pkg::sample_t              sample_out,
  output tws_pkg::psum_t                psum_out
);
  import tws_pkg::*;

  sample_t sample;
  psum_t   psum;
  logic signed [WEIGHT_W+SAMPLE_BITS:0] prod;

  assign prod = $signed({1'b0, weight}) * sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift) begin
      sample <= sample_in;
    end
  end

  always_ff @(posedge clk) begin
    psum <= psum_in + SUM_W'(prod);
  end

  assign sample_out = sample;
  assign psum_out   = psum;

endmodule

// File: design/tws_divider.sv
// restoring signed divider, one quotient bit per cycle, truncating toward zero
module tws_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  tws_pkg::psum_t                 dividend,
  input  logic [tws_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output tws_pkg::sample_t               quotient
);
  import tws_pkg::*;

  logic                 busy;
  logic                 finish;
  logic [STEP_W-1:0]    step;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIVISOR_W-1:0] dvs;
  logic [MAG_W-1:0]     quo;
  logic                 neg;
  logic [DIVISOR_W:0]   trial;
  logic                 qbit;
  logic [SUM_W-1:0]     absval;
  logic [MAG_W-1:0]     qsigned;

  assign absval   = dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
  assign trial    = {rem, quo[MAG_W-1]};
  assign qbit     = trial >= {1'b0, dvs};
  assign rem_next = qbit ? DIVISOR_W'(trial - {1'b0, dvs}) : trial[DIVISOR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      step   <= '0;
    end else begin
      finish <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(MAG_W - 1)) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= absval[MAG_W-1:0];
      neg <= dividend[SUM_W-1];
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[MAG_W-2:0], qbit};
    end
  end

  assign qsigned  = neg ? (MAG_W'(0) - quo) : quo;
  assign quotient = qsigned[SAMPLE_BITS-1:0];
  assign done     = finish;

`include "triangular_window_smoother_core_macros.svh"

  `TWS_ASSERT_NEXT(a_start_busy, clk, rst, start, busy)
  `TWS_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)

endmodule

// File: design/triangular_window_smoother_core.sv
// top level of the triangular window smoother: cell row, divider, control, ports
//
//  channel | direction | transaction content
//  s_*     | in        | tdata: sample[15:0]; tuser: restart
//  m_*     | out       | tdata: smoothed[15:0]; tuser: window_full
//  apb     | in        | word 0: window_size[3:0]
//
// one item at a time: a new input is taken only in idle, after the 15-cell partial-sum pass,
// the load state, the 22-step divider with its done pulse and the move into the output
// register, which waits while a held result there is not yet taken
// the next sample is taken while a finished result waits in the output register
// rst is synchronous, active high; window_size returns to 5, fill count to zero
module triangular_window_smoother_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // sample[15:0]
  input  logic                        s_tuser,   // restart
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // smoothed[15:0]
  output logic                        m_tuser,   // window_full
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tws_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tws_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [WIN_W-1:0]   window_size;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   fill_next;
  logic [CNT_W-1:0]   cnt;
  logic               full;
  logic               accept;
  logic               out_free;
  sample_t            result;
  logic               div_done;
  sample_t            div_quo;

  sample_t            samp [MAX_WINDOW];
  psum_t              psum [MAX_WINDOW];

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == WORD_WINDOW_SIZE) ? {28'd0, window_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == WORD_WINDOW_SIZE) begin
      window_size <= fix_window(pwdata[WIN_W-1:0]);
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_WINDOW; k++) begin : g_cell
      sample_t sin;
      psum_t   pin;
      if (k == 0) begin : g_head
        assign sin = s_tdata;
        assign pin = '0;
      end else begin : g_body
        assign sin = samp[k-1];
        assign pin = psum[k-1];
      end
      tws_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .shift      (accept),
        .sample_in  (sin),
        .weight     (cell_weight(CNT_W'(k), window_size)),
        .psum_in    (pin),
        .sample_out (samp[k]),
        .psum_out   (psum[k])
      );
    end
  endgenerate

  tws_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_LOAD),
    .dividend (psum[MAX_WINDOW-1]),
    .divisor  (weight_total(window_size)),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    if (s_tuser) begin
      fill_next = CNT_W'(1);
    end else if (fill_count < CNT_W'(MAX_WINDOW)) begin
      fill_next = fill_count + 1'b1;
    end else begin
      fill_next = fill_count;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_SUM;
      end
      S_SUM: begin
        if (cnt == CNT_W'(MAX_WINDOW - 1)) state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_PEND;
      end
      S_PEND: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fill_count <= fill_next;
        cnt        <= '0;
      end else if (state == S_SUM) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_PEND && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full <= (fill_next >= window_size);
    end
    if (div_done) begin
      result <= full ? div_quo : '0;
    end
    if (state == S_PEND && out_free) begin
      m_tdata <= result;
      m_tuser <= full;
    end
  end

`include "triangular_window_smoother_core_macros.svh"

  `TWS_ASSERT_SAME(a_done_in_div, clk, rst, div_done, state == S_DIV)
  `TWS_ASSERT_NEXT(a_sum_to_load, clk, rst,
                   state == S_SUM && cnt == CNT_W'(MAX_WINDOW - 1), state == S_LOAD)
  `TWS_ASSERT_SAME(a_empty_is_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  `TWS_ASSERT_NEXT(a_fill_nonzero, clk, rst, accept, fill_count != '0)

endmodule

// File: tb/tb_triangular_window_smoother_core.sv
// testbench for the triangular window smoother core: scoreboard, drivers and run control
`timescale 1ns / 100ps

typedef struct {
  logic [15:0] smoothed;
  logic        full;
} smooth_res_t;

class smoother_checker;
  logic [3:0]       window_reg;
  tws_pkg::sample_t sample_line [tws_pkg::MAX_WINDOW];
  int unsigned      fill_count;
  smooth_res_t      pending_avgs [$];
  int               mismatches;
  int               results_seen;
  int               full_seen;

  function new();
    window_reg   = tws_pkg::WINDOW_RESET;
    fill_count   = 0;
    mismatches   = 0;
    results_seen = 0;
    full_seen    = 0;
    foreach (sample_line[i]) sample_line[i] = '0;
  endfunction

  function void write_window(logic [31:0] value);
    logic [3:0] v;
    v = value[3:0];
    if (!v[0]) begin
      v = (v == 4'd0) ? 4'd1 : v - 4'd1;
    end
    window_reg = v;
  endfunction

  function void note_sample(logic [15:0] data, logic restart);
    int unsigned w;
    int unsigned c;
    int unsigned wt;
    longint      acc;
    smooth_res_t r;
    w = window_reg;
    if (w < 1) w = 1;
    if (w > tws_pkg::MAX_WINDOW) w = tws_pkg::MAX_WINDOW - ((tws_pkg::MAX_WINDOW % 2) ? 0 : 1);
    c = (w + 1) / 2;
    for (int i = tws_pkg::MAX_WINDOW - 1; i > 0; i--) sample_line[i] = sample_line[i-1];
    sample_line[0] = data;
    if (restart) begin
      fill_count = 1;
    end else if (fill_count < tws_pkg::MAX_WINDOW) begin
      fill_count++;
    end
    if (fill_count < w) begin
      r.smoothed = '0;
      r.full     = 1'b0;
    end else begin
      acc = 0;
      for (int i = 0; i < w; i++) begin
        wt = (i < c) ? i + 1 : w - i;
        acc += longint'(wt) * longint'(sample_line[i]);
      end
      acc = acc / longint'(c * c);
      r.smoothed = acc[15:0];
      r.full     = 1'b1;
    end
    pending_avgs.push_back(r);
  endfunction

  function void report(string what, logic [15:0] e_d, logic e_u, logic [15:0] a_d, logic a_u);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected smoothed=%0d full=%0b, got smoothed=%0d full=%0b",
               what, $signed(e_d), e_u, $signed(a_d), a_u);
    end
  endfunction

  function void check_output(logic [15:0] data, logic full);
    smooth_res_t e;
    results_seen++;
    if (pending_avgs.size() == 0) begin
      report("unexpected result", 16'h0, 1'b0, data, full);
    end else begin
      e = pending_avgs.pop_front();
      if (e.full) full_seen++;
      if (e.smoothed !== data || e.full !== full) begin
        report("result", e.smoothed, e.full, data, full);
      end
    end
  endfunction
endclass

module tb_triangular_window_smoother_core;
  import tws_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_WINDOW = {WORD_WINDOW_SIZE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 10;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [15:0]       s_tdata;
  logic              s_tuser;
  logic              m_tvalid;
  logic              m_tready;
  logic [15:0]       m_tdata;
  logic              m_tuser;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  smoother_checker sb;
  logic            quiet;
  logic            hold_req;
  int              cycles;
  int              samples_sent;
  int              windows_used;

  triangular_window_smoother_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_triangular_window_smoother_core NOT OK");
      $finish;
    end
  end

  // transaction monitors
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_sample(s_tdata, s_tuser);
      if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser);
      if (psel && penable && pwrite && pready && paddr == ADDR_WINDOW) begin
        sb.write_window(pwdata);
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        m_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        m_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [15:0] d, input logic r);
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 10);
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = d;
    s_tuser  = r;
    do @(posedge clk); while (!s_tready);
    samples_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tuser  = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_avgs.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = a;
    pwdata  = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (a == ADDR_WINDOW) windows_used++;
  endtask

  task automatic apb_read_check(input logic [ADDR_W-1:0] a, input logic [31:0] exp_val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = a;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== exp_val) begin
      sb.mismatches++;
      if (sb.mismatches <= 10) begin
        $display("mismatch register read: expected %0d, got %0d", exp_val, prdata);
      end
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0: v = 16'h7fff;
      1: v = 16'h8000;
      2: v = 16'hffff;
      3: v = 16'h0000;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic write_and_verify(input logic [31:0] d);
    apb_write(ADDR_WINDOW, d);
    apb_read_check(ADDR_WINDOW, {28'd0, sb.window_reg});
  endtask

  task automatic random_phase(input int n_items);
    int sent;
    int len;
    int w;
    logic noisy;
    sent = 0;
    while (sent < n_items) begin
      w = sb.window_reg;
      len = $urandom_range(1, 2 * w + 6);
      noisy = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len && sent < n_items; k++) begin
        send_sample(pick_sample(), noisy ? 1'($urandom) : (k == 0));
        sent++;
      end
    end
    stop_sending();
  endtask

  initial begin
    logic [3:0] wsel;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    cycles       = 0;
    samples_sent = 0;
    windows_used = 1;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset window, first sequence without restart, extremes
    apb_read_check(ADDR_WINDOW, {28'd0, WINDOW_RESET});
    repeat (5) send_sample(16'h7fff, 1'b0);
    repeat (5) send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hffff, 1'b0);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    stop_sending();
    drain();

    // zero write becomes one
    write_and_verify(32'hfffffff0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7fff, 1'b0);
    stop_sending();
    drain();

    // widest window mid-sequence, then even write
    write_and_verify(32'h0000000f);
    send_sample(16'h1234, 1'b0);
    send_sample(16'h8001, 1'b0);
    stop_sending();
    drain();
    write_and_verify(32'h0000000e);
    send_sample(16'h7ffe, 1'b0);
    stop_sending();
    drain();

    // unused address leaves the window alone
    apb_write(ADDR_UNUSED, 32'h00000003);
    apb_read_check(ADDR_WINDOW, {28'd0, sb.window_reg});
    apb_read_check(ADDR_WINDOW, {28'd0, sb.window_reg});

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: wsel = 4'd15;
        1: wsel = 4'd1;
        2: wsel = 4'd0;
        3: wsel = 4'd14;
        4: wsel = 4'd3;
        default: wsel = 4'($urandom);
      endcase
      write_and_verify({$urandom} & 32'hfffffff0 | {28'd0, wsel});
      if (p == 3) hold_req = 1'b1;
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      random_phase(88);
      drain();
    end

    if (sb.pending_avgs.size() != 0) begin
      sb.mismatches++;
      $display("%0d expected results never arrived", sb.pending_avgs.size());
    end
    $display("covered %0d samples and %0d results (%0d full) over %0d window settings",
             samples_sent, sb.results_seen, sb.full_seen, windows_used);
    $display("including windows 1 and 15, restarts, even and zero writes and a long output stall");
    if (sb.mismatches == 0) begin
      $display("tb_triangular_window_smoother_core OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_triangular_window_smoother_core NOT OK");
    end
    $finish;
  end
endmodule
